// ----- hw/rtl/sad_pkg.sv -----
// Shared types and constants for the sorted array dictionary.
// No dependencies; imported by sad_cell and sorted_array_dictionary.
`timescale 1ns / 1ps

package sad_pkg;

    // Fixed field widths of the stream beats
    localparam int KIND_BITS   = 2;
    localparam int KEY_IN_BITS = 16;
    localparam int VALUE_BITS  = 40;
    localparam int STATUS_BITS = 2;
    localparam int POS_BITS    = 4;
    localparam int COUNT_BITS  = 5;

    // Operation codes carried in s_tuser
    localparam logic [KIND_BITS-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd2;

    // Result codes carried in m_tuser
    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] STATUS_DUPLICATE = 2'd3;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Broadcast control from the controller to every cell
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the broadcast key
        logic do_ins;   // open a slot at the insert point and load the new entry
        logic do_rem;   // close the gap at the matching entry
    } sad_ctl_t;

endpackage

// ----- hw/rtl/sad_cell.sv -----
// One slot of the sorted row: holds a key/value pair and its compare flags.
// Depends on sad_pkg; chained by sorted_array_dictionary.
`timescale 1ns / 1ps

module sad_cell
    import sad_pkg::*;
#(
    parameter int KEY_BITS = 16,
    parameter int CNT_W    = 5,
    parameter int IDX      = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sad_ctl_t              ctl,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [CNT_W-1:0]      count,
    input  logic                  lower_lt,
    input  logic [KEY_BITS-1:0]   lower_key,
    input  logic [VALUE_BITS-1:0] lower_value,
    input  logic [KEY_BITS-1:0]   upper_key,
    input  logic [VALUE_BITS-1:0] upper_value,
    output logic [KEY_BITS-1:0]   key,
    output logic [VALUE_BITS-1:0] value,
    output logic                  lt,
    output logic                  eq
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic                  lt_reg;
    logic                  eq_reg;
    logic                  occupied;

    // Slot holds a live entry when it sits below the fill level
    assign occupied = (MY_IDX < count);

    // Latch compare flags against the broadcast key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end
        else if (ctl.cmp_en)
        begin
            lt_reg <= occupied && (key_reg < in_key);
            eq_reg <= occupied && (key_reg == in_key);
        end
    end

    // Shift the row: slots at or above the insert or remove point move
    always_ff @(posedge clk)
    begin
        if (ctl.do_ins && !lt_reg)
        begin
            if (lower_lt)
            begin
                key_reg   <= in_key;
                value_reg <= in_value;
            end
            else
            begin
                key_reg   <= lower_key;
                value_reg <= lower_value;
            end
        end
        else if (ctl.do_rem && !lt_reg)
        begin
            key_reg   <= upper_key;
            value_reg <= upper_value;
        end
    end

    assign key   = key_reg;
    assign value = value_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

// ----- hw/rtl/sorted_array_dictionary.sv -----
// Sorted key/value dictionary: controller, result register and a row of cells.
// Depends on sad_pkg and sad_cell.
`timescale 1ns / 1ps

// Holds up to DEPTH entries in ascending key order in a row of cells, one
// entry per cell. Every beat on the s side yields exactly one beat on the m
// side. In the accept cycle every cell compares its key with the incoming
// key; once the output register is free, the row shifts by one slot (insert
// or remove) while the result is written to the output register. A new item
// is taken only after that result is registered, so items do not overlap; a
// stalled result holds the block after the compare of the following item.
// Stored entries need no clearing after reset, since the fill count is
// reset to zero.
module sorted_array_dictionary
    import sad_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key[15:0], value[55:16]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // position[3:0], found_value[43:4], count[48:44], zero
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_USE = (KEY_BITS < KEY_IN_BITS) ? KEY_BITS : KEY_IN_BITS;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t                state_reg;
    state_t                state_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [KIND_BITS-1:0]  kind_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;

    logic                  m_tvalid_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [STATUS_BITS-1:0] status_next;
    logic [POS_BITS-1:0]   position_reg;
    logic [POS_BITS-1:0]   position_next;
    logic [VALUE_BITS-1:0] found_reg;
    logic [VALUE_BITS-1:0] found_next;
    logic [COUNT_BITS-1:0] count_out_reg;

    logic                  accept;
    logic                  commit;
    logic                  do_ins;
    logic                  do_rem;
    logic [KEY_BITS-1:0]   in_key;
    logic [KEY_BITS-1:0]   bus_key;
    sad_ctl_t              ctl;

    logic [KEY_BITS-1:0]   cell_key   [DEPTH];
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]      lt_vec;
    logic [DEPTH-1:0]      eq_vec;

    logic                  hit;
    logic                  full;
    logic [IDX_W-1:0]      ins_pos;
    logic [IDX_W-1:0]      hit_pos;
    logic [VALUE_BITS-1:0] hit_value;
    logic                  below_lt;

    // Handshake
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign commit   = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);
    assign in_key   = KEY_BITS'(s_tdata[KEY_USE-1:0]);

    // Hold the accepted item for the shift cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= s_tuser;
            key_reg   <= in_key;
            value_reg <= s_tdata[KEY_IN_BITS +: VALUE_BITS];
        end
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Reduce the cell flags: insert point, match position and matched value
    always_comb
    begin
        ins_pos   = '0;
        hit_pos   = '0;
        hit_value = '0;
        below_lt  = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!lt_vec[i] && below_lt)
            begin
                ins_pos = ins_pos | IDX_W'(i);
            end
            if (eq_vec[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
            end
            hit_value = hit_value | ({VALUE_BITS{eq_vec[i]}} & cell_value[i]);
            below_lt  = lt_vec[i];
        end
    end

    assign hit  = |eq_vec;
    assign full = (count_reg == FULL_CNT);

    // Decode the operation into a result and a row update
    always_comb
    begin
        status_next   = STATUS_NOT_FOUND;
        position_next = '0;
        found_next    = '0;
        count_next    = count_reg;
        do_ins        = 1'b0;
        do_rem        = 1'b0;
        unique case (kind_reg)
            KIND_INSERT:
            begin
                if (hit)
                begin
                    status_next   = STATUS_DUPLICATE;
                    position_next = POS_BITS'(hit_pos);
                end
                else if (full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    status_next   = STATUS_OK;
                    position_next = POS_BITS'(ins_pos);
                    count_next    = count_reg + 1'b1;
                    do_ins        = 1'b1;
                end
            end
            KIND_FIND:
            begin
                if (hit)
                begin
                    status_next   = STATUS_OK;
                    position_next = POS_BITS'(hit_pos);
                    found_next    = hit_value;
                end
            end
            KIND_REMOVE:
            begin
                if (hit)
                begin
                    status_next   = STATUS_OK;
                    position_next = POS_BITS'(hit_pos);
                    found_next    = hit_value;
                    count_next    = count_reg - 1'b1;
                    do_rem        = 1'b1;
                end
            end
            default:
            begin
                status_next = STATUS_NOT_FOUND;
            end
        endcase
    end

    // Fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (commit)
        begin
            count_reg <= count_next;
        end
    end

    // Output valid: set on commit, drop once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (commit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            status_reg    <= status_next;
            position_reg  <= position_next;
            found_reg     <= found_next;
            count_out_reg <= COUNT_BITS'(count_next);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, count_out_reg, found_reg, position_reg};

    // Broadcast to the row: live key while comparing, held item while shifting
    assign bus_key    = (state_reg == ST_IDLE) ? in_key : key_reg;
    assign ctl.cmp_en = accept;
    assign ctl.do_ins = commit && do_ins;
    assign ctl.do_rem = commit && do_rem;

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic                  lo_lt;
        logic [KEY_BITS-1:0]   lo_key;
        logic [VALUE_BITS-1:0] lo_value;
        logic [KEY_BITS-1:0]   up_key;
        logic [VALUE_BITS-1:0] up_value;

        if (i == 0)
        begin : g_bottom
            assign lo_lt    = 1'b1;
            assign lo_key   = '0;
            assign lo_value = '0;
        end
        else
        begin : g_lower
            assign lo_lt    = lt_vec[i-1];
            assign lo_key   = cell_key[i-1];
            assign lo_value = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_top
            assign up_key   = cell_key[i];
            assign up_value = cell_value[i];
        end
        else
        begin : g_upper
            assign up_key   = cell_key[i+1];
            assign up_value = cell_value[i+1];
        end

        sad_cell #(
            .KEY_BITS (KEY_BITS),
            .CNT_W    (CNT_W),
            .IDX      (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .in_key      (bus_key),
            .in_value    (value_reg),
            .count       (count_reg),
            .lower_lt    (lo_lt),
            .lower_key   (lo_key),
            .lower_value (lo_value),
            .upper_key   (up_key),
            .upper_value (up_value),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    // Fill level never passes the row length
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("fill count beyond depth");

    // Sorted unique keys: at most one cell matches
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_EXEC) |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    // Sorted keys: less-than flags form a run from the bottom cell
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == ST_EXEC) |-> (((lt_vec >> 1) & ~lt_vec) == '0))
        else $error("row is not in ascending order");

    // Fill count moves only when an item commits
    assert property (@(posedge clk) disable iff (!rst_n)
                     !commit |=> $stable(count_reg))
        else $error("fill count changed without a commit");

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking bench for the sorted array dictionary: directed table, then random traffic.
// Depends on sad_pkg and sorted_array_dictionary; every result beat is checked in order.
`timescale 1ns / 1ps

module tb;
    import sad_pkg::*;

    localparam int          TABLE_DEPTH = 16;
    localparam int          RANDOM_ITEMS = 750;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;
    localparam int          DIR_ROWS = 14;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [POS_BITS-1:0]    position;
        logic [VALUE_BITS-1:0]  found_value;
        logic [COUNT_BITS-1:0]  count;
    } dict_result_t;

    // One row of the directed table; reps > 1 walks the key by key_step
    typedef struct {
        logic [KIND_BITS-1:0]   kind;
        logic [KEY_IN_BITS-1:0] key;
        logic [KEY_IN_BITS-1:0] key_step;
        logic [VALUE_BITS-1:0]  value;
        int                     reps;
        bit                     typed;
        dict_result_t           res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // Shadow copy of the table contents
    logic [KEY_IN_BITS-1:0] shadow_keys [TABLE_DEPTH];
    logic [VALUE_BITS-1:0]  shadow_vals [TABLE_DEPTH];
    int                     shadow_count = 0;

    dict_result_t pending_results [$];
    stim_row_t    dir_rows [DIR_ROWS];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           calm = 1'b0;
    int           ready_hold = 0;

    sorted_array_dictionary #(
        .DEPTH    (TABLE_DEPTH),
        .KEY_BITS (16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Apply one operation to the shadow table and return the result it yields
    task automatic dict_apply(input logic [KIND_BITS-1:0] kind,
                              input logic [KEY_IN_BITS-1:0] key,
                              input logic [VALUE_BITS-1:0] value,
                              output dict_result_t res);
        int  slot;
        bit  hit;
        slot = 0;
        while (slot < shadow_count && shadow_keys[slot] < key)
            slot++;
        hit = (slot < shadow_count) && (shadow_keys[slot] == key);
        res = '{STATUS_NOT_FOUND, '0, '0, '0};
        if (kind == KIND_INSERT) begin
            if (hit) begin
                res.status   = STATUS_DUPLICATE;
                res.position = slot[POS_BITS-1:0];
            end
            else if (shadow_count >= TABLE_DEPTH) begin
                res.status = STATUS_FULL;
            end
            else begin
                for (int i = shadow_count; i > slot; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_vals[i] = shadow_vals[i-1];
                end
                shadow_keys[slot] = key;
                shadow_vals[slot] = value;
                shadow_count++;
                res.status   = STATUS_OK;
                res.position = slot[POS_BITS-1:0];
            end
        end
        else if ((kind == KIND_FIND || kind == KIND_REMOVE) && hit) begin
            res.status      = STATUS_OK;
            res.position    = slot[POS_BITS-1:0];
            res.found_value = shadow_vals[slot];
            if (kind == KIND_REMOVE) begin
                for (int i = slot; i + 1 < shadow_count; i++) begin
                    shadow_keys[i] = shadow_keys[i+1];
                    shadow_vals[i] = shadow_vals[i+1];
                end
                shadow_count--;
            end
        end
        res.count = shadow_count[COUNT_BITS-1:0];
    endtask

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        else if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Drive one beat, hold it until taken, then record its expected result
    task automatic feed_item(input logic [KIND_BITS-1:0] kind,
                             input logic [KEY_IN_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value,
                             input bit typed,
                             input dict_result_t typed_res);
        int           gap;
        dict_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, key};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        dict_apply(kind, key, value, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // Throttle the result side with random stalls
    always @(posedge clk)
    begin
        if (calm) begin
            m_tready   <= 1'b1;
            ready_hold = 0;
        end
        else if (ready_hold > 0) begin
            ready_hold--;
        end
        else begin
            m_tready   <= ($urandom_range(0, 99) < 65);
            ready_hold = pick_gap();
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        dict_result_t want;
        dict_result_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[3:0], m_tdata[43:4], m_tdata[48:44]};
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: tuser %0d tdata %h",
                       m_tuser, m_tdata);
                fail_count++;
            end
            else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    fail_count++;
                end
                if (got.position !== want.position) begin
                    $error("position: expected %0d, actual %0d",
                           want.position, got.position);
                    fail_count++;
                end
                if (got.found_value !== want.found_value) begin
                    $error("found_value: expected %h, actual %h",
                           want.found_value, got.found_value);
                    fail_count++;
                end
                if (got.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, got.count);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_IN_BITS-1:0] key_pool [24];
        logic [KIND_BITS-1:0]   kind;
        logic [KEY_IN_BITS-1:0] key;
        logic [63:0]            raw;
        dict_result_t           none;
        int                     phase;
        int                     r;

        none = '{STATUS_NOT_FOUND, '0, '0, '0};

        // Empty table, then the key extremes, duplicates and a full table
        dir_rows[0]  = '{KIND_FIND, 16'h0000, 16'h0, 40'h0, 1, 1'b1,
                         '{STATUS_NOT_FOUND, 4'd0, 40'h0, 5'd0}};
        dir_rows[1]  = '{KIND_REMOVE, 16'hFFFF, 16'h0, 40'hFF_FFFF_FFFF, 1, 1'b1,
                         '{STATUS_NOT_FOUND, 4'd0, 40'h0, 5'd0}};
        dir_rows[2]  = '{KIND_UNUSED, 16'h1234, 16'h0, 40'h12_3456_789A, 1, 1'b1,
                         '{STATUS_NOT_FOUND, 4'd0, 40'h0, 5'd0}};
        dir_rows[3]  = '{KIND_INSERT, 16'h0000, 16'h0, 40'h0, 1, 1'b1,
                         '{STATUS_OK, 4'd0, 40'h0, 5'd1}};
        dir_rows[4]  = '{KIND_INSERT, 16'hFFFF, 16'h0, 40'hFF_FFFF_FFFF, 1, 1'b1,
                         '{STATUS_OK, 4'd1, 40'h0, 5'd2}};
        dir_rows[5]  = '{KIND_INSERT, 16'h0000, 16'h0, 40'h55_5555_5555, 1, 1'b1,
                         '{STATUS_DUPLICATE, 4'd0, 40'h0, 5'd2}};
        dir_rows[6]  = '{KIND_FIND, 16'hFFFF, 16'h0, 40'h0, 1, 1'b1,
                         '{STATUS_OK, 4'd1, 40'hFF_FFFF_FFFF, 5'd2}};
        dir_rows[7]  = '{KIND_INSERT, 16'h0800, 16'h1000, 40'hA5_A5A5_A500, 14, 1'b0, none};
        dir_rows[8]  = '{KIND_INSERT, 16'h7777, 16'h0, 40'h77_7777_7777, 1, 1'b1,
                         '{STATUS_FULL, 4'd0, 40'h0, 5'd16}};
        dir_rows[9]  = '{KIND_INSERT, 16'hFFFF, 16'h0, 40'h0, 1, 1'b1,
                         '{STATUS_DUPLICATE, 4'd15, 40'h0, 5'd16}};
        dir_rows[10] = '{KIND_REMOVE, 16'h0000, 16'h0, 40'h0, 1, 1'b1,
                         '{STATUS_OK, 4'd0, 40'h0, 5'd15}};
        dir_rows[11] = '{KIND_REMOVE, 16'hFFFF, 16'h0, 40'h0, 1, 1'b1,
                         '{STATUS_OK, 4'd14, 40'hFF_FFFF_FFFF, 5'd14}};
        dir_rows[12] = '{KIND_FIND, 16'h0800, 16'h0, 40'h0, 1, 1'b0, none};
        dir_rows[13] = '{KIND_UNUSED, 16'hFFFF, 16'h0, 40'hFF_FFFF_FFFF, 1, 1'b1,
                         '{STATUS_NOT_FOUND, 4'd0, 40'h0, 5'd14}};

        // Hold reset, then release it
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int row = 0; row < DIR_ROWS; row++) begin
            for (int n = 0; n < dir_rows[row].reps; n++) begin
                feed_item(dir_rows[row].kind,
                          dir_rows[row].key + KEY_IN_BITS'(n) * dir_rows[row].key_step,
                          dir_rows[row].value + VALUE_BITS'(n),
                          dir_rows[row].typed, dir_rows[row].res);
            end
        end

        // Keys that recur so finds and removes hit and the table fills up
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < 24; i++)
            key_pool[i] = KEY_IN_BITS'($urandom_range(0, 16'hFFFF));

        // Random traffic in phases that grow, shrink or churn the table
        phase = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                phase = $urandom_range(0, 2);
                calm  = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 3)
                kind = KIND_UNUSED;
            else if (phase == 0)
                kind = (r < 63) ? KIND_INSERT : (r < 88) ? KIND_FIND : KIND_REMOVE;
            else if (phase == 1)
                kind = (r < 18) ? KIND_INSERT : (r < 43) ? KIND_FIND : KIND_REMOVE;
            else
                kind = (r < 38) ? KIND_INSERT : (r < 68) ? KIND_FIND : KIND_REMOVE;
            if ($urandom_range(0, 99) < 80)
                key = key_pool[$urandom_range(0, 23)];
            else
                key = KEY_IN_BITS'($urandom_range(0, 16'hFFFF));
            raw = {$urandom, $urandom};
            feed_item(kind, key, raw[VALUE_BITS-1:0], 1'b0, none);
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
